FILE: design/cvpg_pkg.sv
package cvpg_pkg;

	localparam int RAW_W = 17;

	typedef logic [4:0] pen_t;
	typedef logic [RAW_W-1:0] raw_addr_t;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_BLINK  = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	localparam logic [1:0] CFG_LAYOUT = 2'd0;
	localparam logic [1:0] CFG_HIRES  = 2'd1;
	localparam logic [1:0] CFG_BANK   = 2'd2;
	localparam logic [1:0] CFG_BLINK  = 2'd3;

	localparam raw_addr_t SCR_COLOUR_BASE    = 17'h02800;
	localparam raw_addr_t SCR_HIGH_PIX_BASE  = 17'h02000;
	localparam raw_addr_t SCR_HIGH_COLOUR_OFS = 17'h00800;
	localparam raw_addr_t LIN_COLOUR_OFS     = 17'h04000;
	localparam raw_addr_t LIN_BANK_STRIDE    = 17'h08000;

	localparam pen_t FOUR_PENS [4] = '{5'd0, 5'd2, 5'd5, 5'd7};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_COL,
		ST_FORM
	} state_t;

endpackage

FILE: design/cvpg_addr.sv
module cvpg_addr #(
	parameter int RAM_BYTES = 65536,
	localparam int AW = $clog2(RAM_BYTES)
) (
	input  logic          layout_q,
	input  logic          bank_q,
	input  logic [5:0]    column,
	input  logic [7:0]    line,
	input  logic [15:0]   ram_address,
	output logic [AW-1:0] pix_addr,
	output logic [AW-1:0] col_addr,
	output logic [AW-1:0] wr_addr
);
	import cvpg_pkg::*;

	localparam int RW1 = RAW_W + 1;
	localparam int WRAP_STEPS = (1 << RAW_W) / RAM_BYTES;

	raw_addr_t pix_raw;
	raw_addr_t col_raw;
	raw_addr_t lin_off;
	raw_addr_t lin_base;

	// fold an address into the ram size, compares run in parallel
	function automatic logic [AW-1:0] wrap(input raw_addr_t raw);
		logic [RW1-1:0] diff;
		logic [AW-1:0]  r;
		r = raw[AW-1:0];
		for (int k = 1; k <= WRAP_STEPS; k++) begin
			diff = {1'b0, raw} - RW1'(k * RAM_BYTES);
			if ({1'b0, raw} >= RW1'(k * RAM_BYTES)) begin
				r = diff[AW-1:0];
			end
		end
		return r;
	endfunction

	always_comb begin
		lin_off  = {3'b000, column, line};
		lin_base = bank_q ? LIN_BANK_STRIDE : '0;
		if (layout_q) begin
			pix_raw = lin_base + lin_off;
			col_raw = lin_base + LIN_COLOUR_OFS + lin_off;
		end else if (!column[5]) begin
			pix_raw = {4'b0000, line[7:4], line[1:0], line[3:2], column[4:0]};
			col_raw = SCR_COLOUR_BASE + {6'b000000, line[7:2], column[4:0]};
		end else begin
			pix_raw = SCR_HIGH_PIX_BASE
				+ {6'b000000, line[7:6], line[1:0], line[3:2], line[5:4], column[2:0]};
			col_raw = SCR_COLOUR_BASE + SCR_HIGH_COLOUR_OFS
				+ {8'b00000000, line[7:6], line[3:2], line[5:4], column[2:0]};
		end
	end

	assign pix_addr = wrap(pix_raw);
	assign col_addr = wrap(col_raw);
	assign wr_addr  = wrap({1'b0, ram_address});

endmodule

FILE: design/cell_video_pixel_generator.sv
// Character-cell pixel generator with its own byte-wide video ram.
// Input channel (in_valid/in_stall) takes one beat per opcode: a ram byte
// write, a blink phase toggle, or a render of one cell at column/line.
// Only a render of an on-screen column yields an output beat on
// out_valid/out_stall carrying eight pens, pen_0 leftmost.
// A write or toggle never stalls the channel and the next beat may follow at once.
// A render uses the single ram read port twice (pixel byte, then colour
// byte) through ST_RD_COL and ST_FORM; the output register loads in ST_FORM
// and, if the output is free, a new beat is taken in that same cycle.
// The output register holds a finished beat while a new item is worked on;
// if it is still stalled when the next render completes, in_stall stays
// high until the receiver takes the waiting beat.
// After reset the ram is swept to zero, one byte a cycle, over all RAM_BYTES
// addresses; in_stall is high during the sweep. Configuration writes on
// cfg_we/cfg_index/cfg_data are taken at any time, bit 0 only; the
// registers and the blink phase reset to zero.
module cell_video_pixel_generator #(
	parameter int RAM_BYTES    = 65536,
	parameter int CELL_COLUMNS = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic           cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     opcode,
	input  logic [15:0]    ram_address,
	input  logic [7:0]     write_data,
	input  logic [5:0]     column,
	input  logic [7:0]     line,
	output logic           out_valid,
	input  logic           out_stall,
	output cvpg_pkg::pen_t pen_0,
	output cvpg_pkg::pen_t pen_1,
	output cvpg_pkg::pen_t pen_2,
	output cvpg_pkg::pen_t pen_3,
	output cvpg_pkg::pen_t pen_4,
	output cvpg_pkg::pen_t pen_5,
	output cvpg_pkg::pen_t pen_6,
	output cvpg_pkg::pen_t pen_7
);
	import cvpg_pkg::*;

	localparam int AW = $clog2(RAM_BYTES);

	state_t state_q;
	state_t state_d;

	logic          layout_q;
	logic          hires_q;
	logic          bank_q;
	logic          blink_en_q;
	logic          blink_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_last;

	logic [7:0]    vram_q [RAM_BYTES];
	logic [7:0]    rd_data_q;
	logic [7:0]    gb_q;
	logic [AW-1:0] col_addr_q;

	logic [AW-1:0] pix_addr;
	logic [AW-1:0] col_addr;
	logic [AW-1:0] wr_addr;

	logic          accept;
	logic          col_ok;
	logic          render_ok;
	logic          render_go;
	logic          out_free;
	logic          load_out;
	logic          clr_we;
	logic          rd_col;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	logic          out_valid_q;
	pen_t          pens_q [8];
	pen_t          form_pens [8];
	pen_t          fg;
	pen_t          bg;

	cvpg_addr #(.RAM_BYTES(RAM_BYTES)) u_addr (
		.layout_q    (layout_q),
		.bank_q      (bank_q),
		.column      (column),
		.line        (line),
		.ram_address (ram_address),
		.pix_addr    (pix_addr),
		.col_addr    (col_addr),
		.wr_addr     (wr_addr)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign clr_last  = (clr_addr_q == AW'(RAM_BYTES - 1));
	assign col_ok    = ({1'b0, column} < 7'(CELL_COLUMNS));
	assign render_ok = (opcode == OP_RENDER) && col_ok;
	assign accept    = in_valid && !in_stall;
	assign render_go = accept && render_ok;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (render_go) begin
					state_d = ST_RD_COL;
				end
			end
			ST_RD_COL: begin
				state_d = ST_FORM;
			end
			ST_FORM: begin
				if (out_free) begin
					state_d = render_go ? ST_RD_COL : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		load_out = 1'b0;
		clr_we   = 1'b0;
		rd_col   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clr_we = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RD_COL: begin
				rd_col = 1'b1;
			end
			ST_FORM: begin
				in_stall = !out_free;
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// ram port selection
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = wr_addr;
		mem_wd  = write_data;
		rd_en   = rd_col;
		rd_addr = col_addr_q;
		if (clr_we) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (accept && opcode == OP_WRITE) begin
			mem_we = 1'b1;
		end
		if (render_go) begin
			rd_en   = 1'b1;
			rd_addr = pix_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram_q[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= vram_q[rd_addr];
		end
	end

	// pen forming from pixel byte and colour byte
	always_comb begin
		bg = {2'b10, rd_data_q[2:0]};
		fg = {1'b0, rd_data_q[6:3]};
		if (rd_data_q[7] && blink_q && blink_en_q) begin
			fg = bg;
		end
		for (int i = 0; i < 8; i++) begin
			if (hires_q) begin
				form_pens[i] = FOUR_PENS[{rd_data_q[7-i], gb_q[7-i]}];
			end else begin
				form_pens[i] = gb_q[7-i] ? fg : bg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (render_go) begin
			col_addr_q <= col_addr;
		end
		if (rd_col) begin
			gb_q <= rd_data_q;
		end
		if (load_out) begin
			pens_q <= form_pens;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			layout_q    <= 1'b0;
			hires_q     <= 1'b0;
			bank_q      <= 1'b0;
			blink_en_q  <= 1'b0;
			blink_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LAYOUT: layout_q   <= cfg_data;
					CFG_HIRES:  hires_q    <= cfg_data;
					CFG_BANK:   bank_q     <= cfg_data;
					CFG_BLINK:  blink_en_q <= cfg_data;
					default:    layout_q   <= layout_q;
				endcase
			end
			if (accept && opcode == OP_BLINK) begin
				blink_q <= !blink_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pen_0 = pens_q[0];
	assign pen_1 = pens_q[1];
	assign pen_2 = pens_q[2];
	assign pen_3 = pens_q[3];
	assign pen_4 = pens_q[4];
	assign pen_5 = pens_q[5];
	assign pen_6 = pens_q[6];
	assign pen_7 = pens_q[7];

endmodule

FILE: design/cvpg_check.sv
module cvpg_check #(
	parameter int CELL_COLUMNS = 40
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic [1:0]     opcode,
	input logic [5:0]     column,
	input logic           out_valid,
	input logic           out_stall,
	input cvpg_pkg::pen_t pen_0,
	input cvpg_pkg::pen_t pen_7
);
	import cvpg_pkg::*;

	logic in_beat;
	logic render_beat;

	assign in_beat     = in_valid && !in_stall;
	assign render_beat = in_beat && opcode == OP_RENDER
		&& ({1'b0, column} < 7'(CELL_COLUMNS));

	// a held output beat keeps its pens
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pen_0) && $stable(pen_7))
		else $error("output beat changed while stalled");

	// a render holds off input while the ram port reads its colour byte
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		render_beat |=> in_stall)
		else $error("input taken during colour read");

	// an input beat never makes out_valid rise ahead of a render's ST_FORM load
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> ##2 !$rose(out_valid))
		else $error("output beat too early");

	// a fresh output beat comes from a render beat, registered through ST_RD_COL and ST_FORM
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(render_beat, 3))
		else $error("output beat without a render");

endmodule

bind cell_video_pixel_generator cvpg_check #(.CELL_COLUMNS(CELL_COLUMNS)) u_cvpg_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.opcode    (opcode),
	.column    (column),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pen_0     (pen_0),
	.pen_7     (pen_7)
);
